### src/bcld_pkg.sv
// Shared constants for the button click / long press / double click detector.
// Holds field widths, event codes, register indexes and register reset values.
// No dependencies.
package bcld_pkg;

  // Field and register widths.
  localparam int unsigned EventW = 2;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  // Event codes carried on the result channel.
  localparam logic [EventW-1:0] EV_NONE = 2'd0;
  localparam logic [EventW-1:0] EV_CLICK = 2'd1;
  localparam logic [EventW-1:0] EV_LONG = 2'd2;
  localparam logic [EventW-1:0] EV_DOUBLE = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_TICKS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_CLICK_WINDOW = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVEL = 2'd2;

  // Register values after reset.
  localparam logic [CountW-1:0] LONG_PRESS_TICKS_RST = 8'd40;
  localparam logic [CountW-1:0] DOUBLE_CLICK_WINDOW_RST = 8'd10;
  localparam logic ACTIVE_LEVEL_RST = 1'b0;

endpackage

### src/bcld_in_if.sv
// Input channel of the detector: one sampled pin level per transaction.
// Depends on nothing but the valid/ready convention.
interface bcld_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

### src/bcld_out_if.sv
// Result channel of the detector: one button event per transaction.
// Depends on bcld_pkg for the event width.
interface bcld_out_if;
  logic valid;
  logic ready;
  logic [bcld_pkg::EventW-1:0] button_event;

  modport source (output valid, output button_event, input ready);
  modport sink (input valid, input button_event, output ready);
endinterface

### src/button_click_long_double_detector.sv
// Button event detector top level: debounce, long press and double click logic.
// Depends on bcld_pkg, bcld_in_if and bcld_out_if.
//
// Each input transaction carries one sampled pin level (one scan tick) and
// produces exactly one result transaction: none, click, long press or double
// click. The block takes one sample per clock cycle while the input is ready;
// the event for a sample appears in the output register on the cycle after it
// is accepted. The input is ready whenever the output register is empty or is
// being drained in the same cycle, so a waiting result does not stop the next
// sample from entering as long as the sink keeps taking results. Configuration
// writes should be made only while no result is outstanding.
module button_click_long_double_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  bcld_in_if.sink                       in_ch,
  bcld_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [bcld_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bcld_pkg::CfgDataW-1:0] cfg_data
);

  // Press stage phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_HELD = 2'd2;
  localparam logic [1:0] PH_WAITREL = 2'd3;

  localparam logic [bcld_pkg::CountW-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [bcld_pkg::CountW-1:0] long_press_ticks_r;
  logic [bcld_pkg::CountW-1:0] double_click_window_r;
  logic                        active_level_r;

  // Detector state.
  logic [1:0]                  phase_r, phase_nxt;
  logic [bcld_pkg::CountW-1:0] hold_count_r, hold_count_nxt;
  logic                        click_pending_r, click_pending_nxt;
  logic [bcld_pkg::CountW-1:0] window_count_r, window_count_nxt;

  // Output register.
  logic                        out_valid_r;
  logic [bcld_pkg::EventW-1:0] out_event_r, event_nxt;

  logic                        pressed;
  logic                        accept;
  logic [bcld_pkg::EventW-1:0] raw_event;
  logic [bcld_pkg::CountW-1:0] hold_inc;
  logic [bcld_pkg::CountW-1:0] window_inc;

  // Handshake: the output register frees up when empty or drained this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.button_event = out_event_r;

  assign pressed = (in_ch.pin_level == active_level_r);
  assign hold_inc = (hold_count_r == COUNT_MAX) ? hold_count_r : hold_count_r + 1'b1;
  assign window_inc = (window_count_r == COUNT_MAX) ? window_count_r : window_count_r + 1'b1;

  // Press stage: debounce, hold counting and release tracking.
  always_comb begin
    phase_nxt = phase_r;
    hold_count_nxt = hold_count_r;
    raw_event = bcld_pkg::EV_NONE;
    unique case (phase_r)
      PH_IDLE: begin
        if (pressed) phase_nxt = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (pressed) begin
          hold_count_nxt = '0;
          phase_nxt = PH_HELD;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_HELD: begin
        if (pressed) begin
          hold_count_nxt = hold_inc;
          if (hold_inc >= long_press_ticks_r) begin
            raw_event = bcld_pkg::EV_LONG;
            phase_nxt = PH_WAITREL;
          end
        end else begin
          raw_event = bcld_pkg::EV_CLICK;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        if (!pressed) phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Click stage: hold a first click for the window, pair or expire it.
  always_comb begin
    click_pending_nxt = click_pending_r;
    window_count_nxt = window_count_r;
    event_nxt = bcld_pkg::EV_NONE;
    if (!click_pending_r) begin
      if (raw_event == bcld_pkg::EV_CLICK) begin
        window_count_nxt = '0;
        click_pending_nxt = 1'b1;
      end else begin
        event_nxt = raw_event;
      end
    end else if (raw_event == bcld_pkg::EV_CLICK) begin
      event_nxt = bcld_pkg::EV_DOUBLE;
      click_pending_nxt = 1'b0;
    end else begin
      // A long press inside the window is dropped; the window keeps counting.
      window_count_nxt = window_inc;
      if (window_inc >= double_click_window_r) begin
        event_nxt = bcld_pkg::EV_CLICK;
        click_pending_nxt = 1'b0;
      end
    end
  end

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ticks_r <= bcld_pkg::LONG_PRESS_TICKS_RST;
      double_click_window_r <= bcld_pkg::DOUBLE_CLICK_WINDOW_RST;
      active_level_r <= bcld_pkg::ACTIVE_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcld_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_r <= cfg_data;
        bcld_pkg::REG_DOUBLE_CLICK_WINDOW: double_click_window_r <= cfg_data;
        bcld_pkg::REG_ACTIVE_LEVEL: active_level_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State and output valid update on each accepted transaction; valid also clears on a drain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hold_count_r <= '0;
      click_pending_r <= 1'b0;
      window_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        hold_count_r <= hold_count_nxt;
        click_pending_r <= click_pending_nxt;
        window_count_r <= window_count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) out_event_r <= event_nxt;
  end

  // Every accepted sample leaves a result in the output register.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted sample produced no result");

  // Any reported event leaves no click waiting for a partner.
  a_event_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r != bcld_pkg::EV_NONE) |-> !click_pending_r)
    else $error("event reported while a click is still pending");

  // A reported long press leaves the press stage waiting for release.
  a_long_waits_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_event_r == bcld_pkg::EV_LONG) |-> (phase_r == PH_WAITREL))
    else $error("long press reported outside the release wait");

  // State only moves when a sample is accepted.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(phase_r) && $stable(click_pending_r) && $stable(window_count_r)))
    else $error("detector state changed without a sample");

endmodule

### test/button_click_long_double_detector_tb.sv
// Self-checking testbench for the button click / long press / double click detector.
// Depends on bcld_pkg, bcld_in_if, bcld_out_if and button_click_long_double_detector.
// Drives random press gestures, tracks the expected events in a class and checks each result.
`timescale 1ns / 100ps

module button_click_long_double_detector_tb;

  // Keeps its own copy of the registers and the detector state, and holds the
  // events that are still due on the result channel.
  class click_tracker;
    typedef enum logic [1:0] {
      PH_IDLE,
      PH_DEBOUNCE,
      PH_HELD,
      PH_WAIT_RELEASE
    } press_phase_t;

    logic [bcld_pkg::CountW-1:0] long_ticks;
    logic [bcld_pkg::CountW-1:0] dbl_window;
    logic                        act_level;

    press_phase_t                phase;
    logic [bcld_pkg::CountW-1:0] hold_cnt;
    logic [bcld_pkg::CountW-1:0] win_cnt;
    logic                        click_wait;

    logic [bcld_pkg::EventW-1:0] due_events[$];
    int unsigned                 mismatches;
    int unsigned                 samples;
    int unsigned                 event_seen[4];

    function new();
      long_ticks = bcld_pkg::LONG_PRESS_TICKS_RST;
      dbl_window = bcld_pkg::DOUBLE_CLICK_WINDOW_RST;
      act_level  = bcld_pkg::ACTIVE_LEVEL_RST;
      phase      = PH_IDLE;
      hold_cnt   = '0;
      win_cnt    = '0;
      click_wait = 1'b0;
      mismatches = 0;
      samples    = 0;
      foreach (event_seen[i]) event_seen[i] = 0;
    endfunction

    function void set_reg(logic [bcld_pkg::CfgIdxW-1:0] idx,
                          logic [bcld_pkg::CfgDataW-1:0] data);
      case (idx)
        bcld_pkg::REG_LONG_PRESS_TICKS: long_ticks = data;
        bcld_pkg::REG_DOUBLE_CLICK_WINDOW: dbl_window = data;
        bcld_pkg::REG_ACTIVE_LEVEL: act_level = data[0];
        default: ;
      endcase
    endfunction

    function logic [bcld_pkg::CountW-1:0] count_up(logic [bcld_pkg::CountW-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Debounce and hold timing; returns the raw click or long press.
    function logic [bcld_pkg::EventW-1:0] press_step(logic pressed);
      logic [bcld_pkg::EventW-1:0] raw;
      raw = bcld_pkg::EV_NONE;
      case (phase)
        PH_IDLE: begin
          if (pressed) phase = PH_DEBOUNCE;
        end
        PH_DEBOUNCE: begin
          if (pressed) begin
            hold_cnt = '0;
            phase = PH_HELD;
          end else begin
            phase = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (pressed) begin
            hold_cnt = count_up(hold_cnt);
            if (hold_cnt >= long_ticks) begin
              raw = bcld_pkg::EV_LONG;
              phase = PH_WAIT_RELEASE;
            end
          end else begin
            raw = bcld_pkg::EV_CLICK;
            phase = PH_IDLE;
          end
        end
        default: begin
          if (!pressed) phase = PH_IDLE;
        end
      endcase
      return raw;
    endfunction

    // Called for every accepted input transaction.
    function void note_sample(logic pin);
      logic [bcld_pkg::EventW-1:0] raw;
      logic [bcld_pkg::EventW-1:0] ev;
      raw = press_step(pin == act_level);
      ev = bcld_pkg::EV_NONE;
      if (!click_wait) begin
        if (raw == bcld_pkg::EV_CLICK) begin
          win_cnt = '0;
          click_wait = 1'b1;
        end else begin
          ev = raw;
        end
      end else if (raw == bcld_pkg::EV_CLICK) begin
        ev = bcld_pkg::EV_DOUBLE;
        click_wait = 1'b0;
      end else begin
        // A long press inside the window is dropped here.
        win_cnt = count_up(win_cnt);
        if (win_cnt >= dbl_window) begin
          ev = bcld_pkg::EV_CLICK;
          click_wait = 1'b0;
        end
      end
      samples++;
      due_events.push_back(ev);
    endfunction

    // Called for every accepted result transaction.
    function void check_event(logic [bcld_pkg::EventW-1:0] got);
      logic [bcld_pkg::EventW-1:0] want;
      event_seen[got]++;
      if (due_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected event %0d with nothing due", $realtime, got);
      end else begin
        want = due_events.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: event mismatch, expected %0d, got %0d", $realtime, want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bcld_pkg::CfgIdxW-1:0] cfg_index;
  logic [bcld_pkg::CfgDataW-1:0] cfg_data;

  bcld_in_if in_ch ();
  bcld_out_if out_ch ();

  button_click_long_double_detector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  click_tracker tracker = new();
  bit no_idle;
  int unsigned rx_hold;
  int unsigned settings_used;

  // 10 ns clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("button_click_long_double_detector: mismatch");
    $finish;
  end

  // Offers one sample and returns at the edge where the transaction happens.
  task automatic send_sample(input logic pin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pin_level <= pin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_sample(pin);
  endtask

  // Stops offering input and waits until every due event has come out.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; only called while idle.
  task automatic write_settings(input logic [bcld_pkg::CfgDataW-1:0] long_ticks,
                                input logic [bcld_pkg::CfgDataW-1:0] window,
                                input logic level);
    cfg_we <= 1'b1;
    cfg_index <= bcld_pkg::REG_LONG_PRESS_TICKS;
    cfg_data <= long_ticks;
    @(posedge clk);
    cfg_index <= bcld_pkg::REG_DOUBLE_CLICK_WINDOW;
    cfg_data <= window;
    @(posedge clk);
    cfg_index <= bcld_pkg::REG_ACTIVE_LEVEL;
    cfg_data <= {{(bcld_pkg::CfgDataW-1){1'b0}}, level};
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(bcld_pkg::REG_LONG_PRESS_TICKS, long_ticks);
    tracker.set_reg(bcld_pkg::REG_DOUBLE_CLICK_WINDOW, window);
    tracker.set_reg(bcld_pkg::REG_ACTIVE_LEVEL, {{(bcld_pkg::CfgDataW-1){1'b0}}, level});
    settings_used++;
  endtask

  // Mostly press and release gestures sized around the current limits, with
  // some random pin noise mixed in.
  task automatic play_gestures(input int unsigned n_items);
    int unsigned sent;
    int unsigned hold;
    int unsigned gap;
    int unsigned lt;
    int unsigned r;
    logic act;
    sent = 0;
    while (sent < n_items) begin
      act = tracker.act_level;
      lt = tracker.long_ticks;
      r = $urandom_range(0, 9);
      if (r < 2) begin
        repeat ($urandom_range(1, 6)) begin
          send_sample(1'($urandom_range(0, 1)));
          sent++;
        end
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) hold = 1;
        else if (r < 6) hold = $urandom_range(2, lt + 1);
        else if (r < 8) hold = $urandom_range(lt + 1, lt + 3);
        else hold = $urandom_range(lt + 2, lt + 12);
        gap = $urandom_range(1, tracker.dbl_window + 3);
        repeat (hold) send_sample(act);
        repeat (gap) send_sample(~act);
        sent += hold + gap;
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : result_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      tracker.check_event(out_ch.button_event);
    end
  end

  // Main sequence.
  initial begin : stimulus
    string directed;
    int unsigned failures;
    in_ch.valid <= 1'b0;
    in_ch.pin_level <= 1'b0;
    out_ch.ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= bcld_pkg::REG_LONG_PRESS_TICKS;
    cfg_data <= '0;
    rst_n <= 1'b0;
    no_idle = 1'b0;
    rx_hold = 0;
    settings_used = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register values straight out of reset, then a run of released samples
    // so that the press and click stages are both back at rest.
    play_gestures(100);
    repeat (14) send_sample(~tracker.act_level);
    wait_quiet();

    // Directed: bounce, click with window expiry, double click, long press
    // with release, and a long press dropped inside the click window.
    write_settings(8'd1, 8'd4, 1'b1);
    directed = "101100000110110111101101110";
    for (int i = 0; i < directed.len(); i++) send_sample(directed[i] == "1");
    wait_quiet();

    // Zero limits.
    write_settings(8'd0, 8'd0, 1'b0);
    play_gestures(60);
    wait_quiet();

    // Largest limits, so both counters can count up to their maximum value.
    no_idle = 1'b1;
    write_settings(8'd255, 8'd255, 1'b1);
    play_gestures(350);
    wait_quiet();
    no_idle = 1'b0;

    // Smallest legal limits while the result side holds off for a while.
    write_settings(8'd1, 8'd1, 1'b0);
    rx_hold = 80;
    play_gestures(80);
    wait_quiet();

    // Random settings.
    repeat (6) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_settings(($urandom_range(0, 3) == 0) ? 8'($urandom_range(17, 64))
                                                 : 8'($urandom_range(1, 16)),
                     8'($urandom_range(1, 16)), 1'($urandom_range(0, 1)));
      play_gestures(110);
      wait_quiet();
    end

    repeat (20) @(posedge clk);
    failures = tracker.mismatches + tracker.due_events.size();
    $display("Checked %0d samples over %0d register settings.",
             tracker.samples, settings_used);
    $display("Events seen: %0d click, %0d long press, %0d double click.",
             tracker.event_seen[bcld_pkg::EV_CLICK],
             tracker.event_seen[bcld_pkg::EV_LONG],
             tracker.event_seen[bcld_pkg::EV_DOUBLE]);
    if (failures == 0) begin
      $display("button_click_long_double_detector: match");
    end else begin
      $display("button_click_long_double_detector: mismatch");
    end
    $finish;
  end

endmodule
